/* sv/kfis_pkg.sv */
package kfis_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int KEY_W      = $clog2(MAX_KEYS);
    localparam int CNT_W      = 7;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);

    typedef enum logic [1:0] {
        REG_KEY_COUNT = 2'd0,
        REG_DURATION  = 2'd1,
        REG_WRAP_MODE = 2'd2,
        REG_SPARE     = 2'd3
    } cfg_reg_t;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENDS,
        ST_CLASS,
        ST_SCAN,
        ST_SCAN_CHECK,
        ST_FETCH,
        ST_DIVIDE,
        ST_READ_VAL,
        ST_MULT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_FIRST,
        RD_LAST,
        RD_SCAN,
        RD_PAIR
    } rd_sel_t;

    typedef struct packed {
        logic    load_start;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    latch_first;
        logic    classify;
        logic    scan_step;
        logic    latch_hit;
        logic    set_last_pair;
        logic    div_start;
        logic    div_step;
        logic    latch_vals;
        logic    mult;
        logic    emit;
        logic    emit_empty;
    } ctrl_t;

    typedef struct packed {
        logic is_query;
        logic empty;
        logic in_span;
        logic scan_hit;
        logic scan_end;
        logic div_done;
    } stat_t;

endpackage

/* sv/keyframe_interpolation_sampler_unit.sv */
// Keyframe sampler: one request per start pulse while busy is low. A load writes one table
// slot and answers with all-zero fields; a query's answer time is set by a linear key
// search, run only when the tick lies within the key span, and by a one-bit-a-cycle
// fraction divider. Each result shows for one cycle on done, and the receiver cannot
// stall it. Write configuration only while busy is low.
module keyframe_interpolation_sampler_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               command,
    input  logic [5:0]         key_index,
    input  logic [31:0]        key_time,
    input  logic signed [31:0] key_x,
    input  logic signed [31:0] key_y,
    input  logic signed [31:0] key_z,
    input  logic [31:0]        tick,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic [5:0]         prev_key,
    output logic [5:0]         next_key,
    output logic [16:0]        fraction,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               empty_res
);

    kfis_pkg::ctrl_t ctrl;
    kfis_pkg::stat_t stat;

    logic [kfis_pkg::CNT_W-1:0] key_count_reg;
    logic [31:0]                duration_reg;
    logic                       wrap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            duration_reg  <= '0;
            wrap_reg      <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (kfis_pkg::cfg_reg_t'(cfg_index))
                kfis_pkg::REG_KEY_COUNT: key_count_reg <= cfg_data[kfis_pkg::CNT_W-1:0];
                kfis_pkg::REG_DURATION:  duration_reg  <= cfg_data;
                kfis_pkg::REG_WRAP_MODE: wrap_reg      <= cfg_data[0];
                default:                 wrap_reg      <= wrap_reg;
            endcase
        end
    end

    kfis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    kfis_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .cfg_key_count (key_count_reg),
        .cfg_duration  (duration_reg),
        .cfg_wrap      (wrap_reg),
        .command       (command),
        .key_index     (key_index),
        .key_time      (key_time),
        .key_x         (key_x),
        .key_y         (key_y),
        .key_z         (key_z),
        .tick          (tick),
        .done          (done),
        .prev_key      (prev_key),
        .next_key      (next_key),
        .fraction      (fraction),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .empty_res     (empty_res)
    );

endmodule

/* sv/kfis_ctrl.sv */
module kfis_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  kfis_pkg::stat_t stat,
    output logic            busy,
    output kfis_pkg::ctrl_t ctrl
);

    kfis_pkg::state_t state_reg;
    kfis_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kfis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kfis_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = kfis_pkg::ST_ENDS;
                end
            end
            kfis_pkg::ST_ENDS:
            begin
                priority if (!stat.is_query || stat.empty)
                begin
                    state_next = kfis_pkg::ST_DONE;
                end
                else
                begin
                    state_next = kfis_pkg::ST_CLASS;
                end
            end
            kfis_pkg::ST_CLASS:
            begin
                if (stat.in_span)
                begin
                    state_next = kfis_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = kfis_pkg::ST_FETCH;
                end
            end
            kfis_pkg::ST_SCAN:
            begin
                state_next = kfis_pkg::ST_SCAN_CHECK;
            end
            kfis_pkg::ST_SCAN_CHECK:
            begin
                priority if (stat.scan_hit || stat.scan_end)
                begin
                    state_next = kfis_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = kfis_pkg::ST_SCAN;
                end
            end
            kfis_pkg::ST_FETCH:
            begin
                state_next = kfis_pkg::ST_DIVIDE;
            end
            kfis_pkg::ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = kfis_pkg::ST_READ_VAL;
                end
            end
            kfis_pkg::ST_READ_VAL:
            begin
                state_next = kfis_pkg::ST_MULT;
            end
            kfis_pkg::ST_MULT:
            begin
                state_next = kfis_pkg::ST_DONE;
            end
            kfis_pkg::ST_DONE:
            begin
                state_next = kfis_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kfis_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.rd_sel = kfis_pkg::RD_FIRST;
        busy = (state_reg != kfis_pkg::ST_IDLE);
        unique case (state_reg)
            kfis_pkg::ST_IDLE:
            begin
                ctrl.load_start = start;
                ctrl.rd_en      = start;
                ctrl.rd_sel     = kfis_pkg::RD_FIRST;
            end
            kfis_pkg::ST_ENDS:
            begin
                ctrl.latch_first = 1'b1;
                ctrl.rd_en       = 1'b1;
                ctrl.rd_sel      = kfis_pkg::RD_LAST;
            end
            kfis_pkg::ST_CLASS:
            begin
                ctrl.classify   = 1'b1;
            end
            kfis_pkg::ST_SCAN:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_sel = kfis_pkg::RD_SCAN;
            end
            kfis_pkg::ST_SCAN_CHECK:
            begin
                ctrl.latch_hit     = stat.scan_hit;
                ctrl.set_last_pair = !stat.scan_hit && stat.scan_end;
                ctrl.scan_step     = 1'b1;
            end
            kfis_pkg::ST_FETCH:
            begin
                ctrl.div_start = 1'b1;
            end
            kfis_pkg::ST_DIVIDE:
            begin
                ctrl.div_step = 1'b1;
                ctrl.rd_en    = stat.div_done;
                ctrl.rd_sel   = kfis_pkg::RD_PAIR;
            end
            kfis_pkg::ST_READ_VAL:
            begin
                ctrl.latch_vals = 1'b1;
            end
            kfis_pkg::ST_MULT:
            begin
                ctrl.mult = 1'b1;
            end
            kfis_pkg::ST_DONE:
            begin
                ctrl.emit       = 1'b1;
                ctrl.emit_empty = stat.is_query && stat.empty;
            end
            default:
            begin
                ctrl.emit = 1'b0;
            end
        endcase
    end

endmodule

/* sv/kfis_dp.sv */
module kfis_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kfis_pkg::ctrl_t                ctrl,
    output kfis_pkg::stat_t                stat,
    input  logic [kfis_pkg::CNT_W-1:0]     cfg_key_count,
    input  logic [31:0]                    cfg_duration,
    input  logic                           cfg_wrap,
    input  logic                           command,
    input  logic [5:0]                     key_index,
    input  logic [31:0]                    key_time,
    input  logic signed [31:0]             key_x,
    input  logic signed [31:0]             key_y,
    input  logic signed [31:0]             key_z,
    input  logic [31:0]                    tick,
    output logic                           done,
    output logic [5:0]                     prev_key,
    output logic [5:0]                     next_key,
    output logic [16:0]                    fraction,
    output logic signed [31:0]             out_x,
    output logic signed [31:0]             out_y,
    output logic signed [31:0]             out_z,
    output logic                           empty_res
);

    localparam int KW = kfis_pkg::KEY_W;
    localparam int FB = kfis_pkg::FRAC_BITS;
    localparam int FW = kfis_pkg::FRAC_W;

    logic [31:0] time_mem [kfis_pkg::MAX_KEYS];
    logic [31:0] x_mem    [kfis_pkg::MAX_KEYS];
    logic [31:0] y_mem    [kfis_pkg::MAX_KEYS];
    logic [31:0] z_mem    [kfis_pkg::MAX_KEYS];

    logic [31:0] trd_reg;
    logic [31:0] xa_reg, ya_reg, za_reg, xb_reg, yb_reg, zb_reg;
    logic [KW-1:0] rd_addr;

    logic          cmd_reg;
    logic [31:0]   tick_reg;
    logic [KW:0]   n_reg;
    logic [31:0]   tfirst_reg, tprev_reg;
    logic [KW:0]   idx_reg;
    logic [KW-1:0] prev_reg, next_reg;
    logic signed [34:0] num_reg, span_reg;
    logic          same_reg;
    logic [FW-1:0] frac_reg;
    logic [FB+34:0] rem_reg;
    logic [FB:0]    quo_reg;
    logic [kfis_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic          div_run_reg;

    logic [KW:0]   n_eff;
    logic          wr_ok;
    logic signed [34:0] gap;
    logic [KW-1:0] last_idx;

    logic signed [33:0] dx, dy, dz;
    logic signed [51:0] px, py, pz;
    logic signed [31:0] vx, vy, vz;

    assign n_eff = (cfg_key_count > kfis_pkg::CNT_W'(kfis_pkg::MAX_KEYS))
                   ? (KW+1)'(kfis_pkg::MAX_KEYS) : (KW+1)'(cfg_key_count);
    assign last_idx = KW'(n_reg - (KW+1)'(1));
    assign wr_ok = ({1'b0, key_index} < 7'(kfis_pkg::MAX_KEYS));

    always_comb
    begin
        unique case (ctrl.rd_sel)
            kfis_pkg::RD_FIRST: rd_addr = '0;
            kfis_pkg::RD_LAST:  rd_addr = last_idx;
            kfis_pkg::RD_SCAN:  rd_addr = idx_reg[KW-1:0];
            kfis_pkg::RD_PAIR:  rd_addr = prev_reg;
            default:            rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_start && command == kfis_pkg::CMD_LOAD && wr_ok)
        begin
            time_mem[key_index[KW-1:0]] <= key_time;
            x_mem[key_index[KW-1:0]]    <= key_x;
            y_mem[key_index[KW-1:0]]    <= key_y;
            z_mem[key_index[KW-1:0]]    <= key_z;
        end
        if (ctrl.rd_en)
        begin
            trd_reg <= time_mem[rd_addr];
            xa_reg  <= x_mem[rd_addr];
            ya_reg  <= y_mem[rd_addr];
            za_reg  <= z_mem[rd_addr];
            xb_reg  <= x_mem[next_reg];
            yb_reg  <= y_mem[next_reg];
            zb_reg  <= z_mem[next_reg];
        end
    end

    assign gap = $signed({3'b000, cfg_duration}) - $signed({3'b000, trd_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= 1'b0;
            n_reg       <= '0;
            div_run_reg <= 1'b0;
            cnt_reg     <= '0;
            done        <= 1'b0;
        end
        else
        begin
            done <= ctrl.emit;
            if (ctrl.load_start)
            begin
                cmd_reg <= command;
                n_reg   <= n_eff;
            end
            if (ctrl.div_start)
            begin
                div_run_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (ctrl.div_step && div_run_reg)
            begin
                if (cnt_reg == kfis_pkg::DIV_CNT_W'(FB))
                begin
                    div_run_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_start)
        begin
            tick_reg <= tick;
        end
        if (ctrl.latch_first)
        begin
            tfirst_reg <= trd_reg;
        end
        if (ctrl.classify)
        begin
            idx_reg   <= (KW+1)'(1);
            tprev_reg <= tfirst_reg;
            priority if (tick_reg < tfirst_reg)
            begin
                if (cfg_wrap)
                begin
                    prev_reg <= last_idx;
                    next_reg <= '0;
                    num_reg  <= gap + $signed({3'b000, tick_reg});
                    span_reg <= gap + $signed({3'b000, tfirst_reg});
                end
                else
                begin
                    prev_reg <= '0;
                    next_reg <= '0;
                    num_reg  <= '0;
                    span_reg <= '0;
                end
            end
            else if (tick_reg > trd_reg)
            begin
                prev_reg   <= last_idx;
                if (cfg_wrap)
                begin
                    next_reg <= '0;
                    num_reg  <= $signed({3'b000, tick_reg}) - $signed({3'b000, trd_reg});
                    span_reg <= gap + $signed({3'b000, tfirst_reg});
                end
                else
                begin
                    next_reg <= last_idx;
                    num_reg  <= '0;
                    span_reg <= '0;
                end
            end
            else
            begin
                prev_reg   <= last_idx;
                next_reg   <= last_idx;
                num_reg    <= '0;
                span_reg   <= '0;
            end
        end
        if (ctrl.scan_step)
        begin
            idx_reg   <= idx_reg + 1'b1;
            tprev_reg <= trd_reg;
        end
        if (ctrl.latch_hit)
        begin
            prev_reg <= KW'(idx_reg - (KW+1)'(1));
            next_reg <= idx_reg[KW-1:0];
            num_reg  <= $signed({3'b000, tick_reg}) - $signed({3'b000, tprev_reg});
            span_reg <= $signed({3'b000, trd_reg}) - $signed({3'b000, tprev_reg});
        end
        if (ctrl.set_last_pair)
        begin
            prev_reg <= last_idx;
            next_reg <= last_idx;
        end
        if (ctrl.div_start)
        begin
            same_reg <= (prev_reg == next_reg);
            quo_reg  <= '0;
            priority if (span_reg <= 0 || num_reg <= 0)
            begin
                frac_reg <= '0;
                rem_reg  <= '0;
            end
            else if (num_reg >= span_reg)
            begin
                frac_reg <= FW'(1) << FB;
                rem_reg  <= '0;
            end
            else
            begin
                frac_reg <= '0;
                rem_reg  <= (FB+35)'(num_reg);
            end
        end
        else if (ctrl.div_step && div_run_reg)
        begin
            if (!(span_reg <= 0 || num_reg <= 0 || num_reg >= span_reg))
            begin
                if (cnt_reg == '0)
                begin
                    rem_reg <= rem_reg;
                end
                else
                begin
                    if ({rem_reg[FB+33:0], 1'b0} >= (FB+35)'(span_reg))
                    begin
                        rem_reg <= {rem_reg[FB+33:0], 1'b0} - (FB+35)'(span_reg);
                        quo_reg <= {quo_reg[FB-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[FB+33:0], 1'b0};
                        quo_reg <= {quo_reg[FB-1:0], 1'b0};
                    end
                end
            end
        end
        if (ctrl.latch_vals && !(span_reg <= 0 || num_reg <= 0 || num_reg >= span_reg))
        begin
            frac_reg <= FW'(quo_reg);
        end
    end

    assign stat.is_query = (cmd_reg == kfis_pkg::CMD_QUERY);
    assign stat.empty    = (n_reg == '0);
    assign stat.in_span  = (tick_reg >= tfirst_reg) && (tick_reg <= trd_reg);
    assign stat.scan_hit = (idx_reg < n_reg) && (trd_reg > tick_reg);
    assign stat.scan_end = (idx_reg + 1'b1 >= n_reg);
    assign stat.div_done = !div_run_reg;

    assign dx = 34'(signed'(xb_reg)) - 34'(signed'(xa_reg));
    assign dy = 34'(signed'(yb_reg)) - 34'(signed'(ya_reg));
    assign dz = 34'(signed'(zb_reg)) - 34'(signed'(za_reg));
    assign px = 52'(dx) * $signed({35'd0, frac_reg});
    assign py = 52'(dy) * $signed({35'd0, frac_reg});
    assign pz = 52'(dz) * $signed({35'd0, frac_reg});
    assign vx = same_reg ? signed'(xa_reg) : 32'(signed'(xa_reg) + 32'(px >>> FB));
    assign vy = same_reg ? signed'(ya_reg) : 32'(signed'(ya_reg) + 32'(py >>> FB));
    assign vz = same_reg ? signed'(za_reg) : 32'(signed'(za_reg) + 32'(pz >>> FB));

    always_ff @(posedge clk)
    begin
        if (ctrl.mult)
        begin
            out_x    <= vx;
            out_y    <= vy;
            out_z    <= vz;
            prev_key <= 6'(prev_reg);
            next_key <= 6'(next_reg);
            fraction <= 17'(frac_reg);
            empty_res <= 1'b0;
        end
        if (ctrl.emit && !(stat.is_query && !stat.empty))
        begin
            out_x     <= '0;
            out_y     <= '0;
            out_z     <= '0;
            prev_key  <= '0;
            next_key  <= '0;
            fraction  <= '0;
            empty_res <= ctrl.emit_empty;
        end
    end

endmodule
